>>> hw/rtl/assert_macros.svh
// assertion macros for the url component splitter rtl
// no dependencies; bodies are empty when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("implication check failed");

`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`else

`define ASSERT_IMPL(label, clk, rstn, ante, cons)

`define ASSERT_NEXT(label, clk, rstn, ante, cons)

`endif

`endif

>>> hw/rtl/urlcs_pkg.sv
// types and constants for the url component splitter
// no dependencies
`default_nettype none

package urlcs_pkg;

    typedef enum logic [3:0] {
        PH_SCHEME = 4'd0,
        PH_SLASH1 = 4'd1,
        PH_SLASH2 = 4'd2,
        PH_HOST   = 4'd3,
        PH_PORT   = 4'd4,
        PH_PATH   = 4'd5,
        PH_QUERY  = 4'd6,
        PH_FRAG   = 4'd7,
        PH_REJECT = 4'd8
    } phase_t;

    typedef enum logic [2:0] {
        PART_SCHEME  = 3'd0,
        PART_HOST    = 3'd1,
        PART_PORT    = 3'd2,
        PART_PATH    = 3'd3,
        PART_QUERY   = 3'd4,
        PART_FRAG    = 3'd5,
        PART_DELIM   = 3'd6,
        PART_IGNORED = 3'd7
    } part_t;

    typedef enum logic [1:0] {
        VERDICT_PENDING = 2'd0,
        VERDICT_ACCEPT  = 2'd1,
        VERDICT_REJECT  = 2'd2
    } verdict_t;

    typedef struct packed {
        part_t    part;
        verdict_t verdict;
        phase_t   phase_next;
    } urlcs_step_t;

    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_SLASH = 8'h2F;
    localparam logic [7:0] CHAR_QMARK = 8'h3F;
    localparam logic [7:0] CHAR_HASH  = 8'h23;

endpackage

`default_nettype wire

>>> hw/rtl/urlcs_classify.sv
// per-byte tagging and phase update of the url splitter
// depends on urlcs_pkg
`default_nettype none

module urlcs_classify
    import urlcs_pkg::*;
(
    input  phase_t      phase,
    input  logic [7:0]  char_in,
    input  logic        end_mark,
    output urlcs_step_t step
);

    part_t    part;
    phase_t   nxt;
    verdict_t verdict;
    logic     is_letter;

    assign is_letter = char_in inside {[8'h41:8'h5A], [8'h61:8'h7A]};

    always_comb begin
        nxt  = phase;
        part = PART_IGNORED;
        case (phase)
            PH_SCHEME: begin
                if (char_in == CHAR_COLON) begin
                    part = PART_DELIM;
                    nxt  = PH_SLASH1;
                end else if (is_letter) begin
                    part = PART_SCHEME;
                end else begin
                    nxt = PH_REJECT;
                end
            end
            PH_SLASH1: begin
                if (char_in == CHAR_SLASH) begin
                    part = PART_DELIM;
                    nxt  = PH_SLASH2;
                end else begin
                    nxt = PH_REJECT;
                end
            end
            PH_SLASH2: begin
                if (char_in == CHAR_SLASH) begin
                    part = PART_DELIM;
                    nxt  = PH_HOST;
                end else begin
                    nxt = PH_REJECT;
                end
            end
            PH_HOST: begin
                if (char_in == CHAR_COLON) begin
                    part = PART_DELIM;
                    nxt  = PH_PORT;
                end else if (char_in == CHAR_SLASH) begin
                    part = PART_DELIM;
                    nxt  = PH_PATH;
                end else begin
                    part = PART_HOST;
                end
            end
            PH_PORT: begin
                if (char_in == CHAR_SLASH) begin
                    part = PART_DELIM;
                    nxt  = PH_PATH;
                end else begin
                    part = PART_PORT;
                end
            end
            PH_PATH: begin
                if (char_in == CHAR_QMARK) begin
                    part = PART_DELIM;
                    nxt  = PH_QUERY;
                end else if (char_in == CHAR_HASH) begin
                    part = PART_DELIM;
                    nxt  = PH_FRAG;
                end else begin
                    part = PART_PATH;
                end
            end
            PH_QUERY: begin
                if (char_in == CHAR_HASH) begin
                    part = PART_DELIM;
                    nxt  = PH_FRAG;
                end else begin
                    part = PART_QUERY;
                end
            end
            PH_FRAG: begin
                part = PART_FRAG;
            end
            default: begin
                part = PART_IGNORED;
                nxt  = PH_REJECT;
            end
        endcase

        if (nxt == PH_REJECT) begin
            verdict = VERDICT_REJECT;
        end else if (end_mark) begin
            verdict = (nxt == PH_PATH || nxt == PH_QUERY || nxt == PH_FRAG)
                      ? VERDICT_ACCEPT : VERDICT_REJECT;
        end else begin
            verdict = VERDICT_PENDING;
        end

        step.part       = part;
        step.verdict    = verdict;
        step.phase_next = end_mark ? PH_SCHEME : nxt;
    end

endmodule

`default_nettype wire

>>> hw/rtl/url_component_splitter.sv
// url component splitter top level: input register, tagging logic, result register
// depends on urlcs_pkg, urlcs_classify and assert_macros.svh
//
// usage:
//   the s_ channel takes one url byte per word (s_char_in) with s_end_mark set on
//   the last byte of a url. the m_ channel returns exactly one word per input
//   word: the byte itself, its part tag, the verdict and the echoed end mark.
//   throughput is one word per cycle, sustained while m_ready is high, with no
//   bubbles between urls; the phase register is read and updated in the same
//   cycle by the tagging logic. an accepted word passes through the input
//   register and then the result register before m_valid shows it.
//   when m_ready is low both registers fill and s_ready drops after two words
//   are held; no word is lost or repeated, and s_ready returns as soon as the
//   result register drains.
//   reset (aresetn low, synchronous) empties both registers and puts the phase
//   at the start of a scheme; a url that was partly received is dropped.
`default_nettype none
`include "assert_macros.svh"

module url_component_splitter
    import urlcs_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,

    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [7:0] s_char_in,
    input  wire logic       s_end_mark,

    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [7:0]      m_char_out,
    output logic [2:0]      m_part,
    output logic [1:0]      m_verdict,
    output logic            m_end_out
);

    logic        in_valid_reg;
    logic [7:0]  in_char_reg;
    logic        in_last_reg;

    logic        out_valid_reg;
    logic [7:0]  out_char_reg;
    part_t       out_part_reg;
    verdict_t    out_verdict_reg;
    logic        out_last_reg;

    phase_t      phase_reg;
    phase_t      phase_next;

    logic        out_ready;
    logic        advance;
    urlcs_step_t step;

    assign out_ready = !out_valid_reg || m_ready;
    assign advance   = in_valid_reg && out_ready;
    assign s_ready   = !in_valid_reg || out_ready;

    urlcs_classify u_classify (
        .phase    (phase_reg),
        .char_in  (in_char_reg),
        .end_mark (in_last_reg),
        .step     (step)
    );

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
        if (s_ready && s_valid) begin
            in_char_reg <= s_char_in;
            in_last_reg <= s_end_mark;
        end
    end

    // phase state
    always_comb begin
        phase_next = phase_reg;
        if (advance) begin
            phase_next = step.phase_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_SCHEME;
        end else begin
            phase_reg <= phase_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_ready) begin
            out_valid_reg <= in_valid_reg;
        end
        if (advance) begin
            out_char_reg    <= in_char_reg;
            out_part_reg    <= step.part;
            out_verdict_reg <= step.verdict;
            out_last_reg    <= in_last_reg;
        end
    end

    assign m_valid    = out_valid_reg;
    assign m_char_out = out_char_reg;
    assign m_part     = out_part_reg;
    assign m_verdict  = out_verdict_reg;
    assign m_end_out  = out_last_reg;

    `ASSERT_NEXT(a_phase_restart, aclk, aresetn, advance && in_last_reg, phase_reg == PH_SCHEME)
    `ASSERT_IMPL(a_accept_on_end, aclk, aresetn,
                 m_valid && m_verdict == VERDICT_ACCEPT, m_end_out)
    `ASSERT_IMPL(a_ignored_rejects, aclk, aresetn,
                 m_valid && m_part == PART_IGNORED, m_verdict == VERDICT_REJECT)
    `ASSERT_NEXT(a_reject_sticks, aclk, aresetn,
                 advance && phase_reg == PH_REJECT, m_verdict == VERDICT_REJECT)

endmodule

`default_nettype wire

>>> tb/sv/tb.sv
// testbench for url_component_splitter: directed table then random urls, checked word by word
// depends on urlcs_pkg and url_component_splitter
`timescale 1ns / 1ps

module tb;
    import urlcs_pkg::*;

    localparam int RANDOM_WORDS = 2000;
    localparam int STALL_AFTER  = 300;
    localparam int STALL_CYCLES = 200;
    localparam int IDLE_LIMIT   = 4000;
    localparam int DRAIN_CYCLES = 10;

    typedef struct packed {
        logic [7:0] byte_val;
        part_t      part;
        verdict_t   verdict;
        logic       is_last;
    } url_word_t;

    typedef struct {
        logic [7:0] ch;
        logic       is_last;
        logic       typed;
        part_t      part;
        verdict_t   verdict;
    } stim_t;

    logic       aclk;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    logic [7:0] s_char_in;
    logic       s_end_mark;
    logic       m_valid;
    logic       m_ready;
    logic [7:0] m_char_out;
    logic [2:0] m_part;
    logic [1:0] m_verdict;
    logic       m_end_out;

    stim_t     stim[$];
    url_word_t want_q[$];
    phase_t    url_phase = PH_SCHEME;
    int        errors = 0;
    int        words_in = 0;
    int        words_out = 0;
    int        idle_cycles = 0;
    bit        stall_done = 0;

    url_word_t got_w;
    url_word_t want_w;
    url_word_t pred_w;
    stim_t     cur_s;

    url_component_splitter dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_char_in  (s_char_in),
        .s_end_mark (s_end_mark),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_char_out (m_char_out),
        .m_part     (m_part),
        .m_verdict  (m_verdict),
        .m_end_out  (m_end_out)
    );

    initial aclk = 1'b0;
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic bit is_letter(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
    endfunction

    // tags one byte and advances the url phase
    function automatic url_word_t tag_byte(input logic [7:0] c, input logic lst);
        url_word_t r;
        phase_t    nxt;
        nxt = url_phase;
        r.byte_val = c;
        r.is_last = lst;
        r.verdict = VERDICT_PENDING;
        r.part = PART_IGNORED;
        case (url_phase)
            PH_SCHEME: begin
                if (c == CHAR_COLON) begin
                    r.part = PART_DELIM;
                    nxt = PH_SLASH1;
                end else if (is_letter(c)) begin
                    r.part = PART_SCHEME;
                end else begin
                    nxt = PH_REJECT;
                end
            end
            PH_SLASH1: begin
                if (c == CHAR_SLASH) begin
                    r.part = PART_DELIM;
                    nxt = PH_SLASH2;
                end else begin
                    nxt = PH_REJECT;
                end
            end
            PH_SLASH2: begin
                if (c == CHAR_SLASH) begin
                    r.part = PART_DELIM;
                    nxt = PH_HOST;
                end else begin
                    nxt = PH_REJECT;
                end
            end
            PH_HOST: begin
                if (c == CHAR_COLON) begin
                    r.part = PART_DELIM;
                    nxt = PH_PORT;
                end else if (c == CHAR_SLASH) begin
                    r.part = PART_DELIM;
                    nxt = PH_PATH;
                end else begin
                    r.part = PART_HOST;
                end
            end
            PH_PORT: begin
                if (c == CHAR_SLASH) begin
                    r.part = PART_DELIM;
                    nxt = PH_PATH;
                end else begin
                    r.part = PART_PORT;
                end
            end
            PH_PATH: begin
                if (c == CHAR_QMARK) begin
                    r.part = PART_DELIM;
                    nxt = PH_QUERY;
                end else if (c == CHAR_HASH) begin
                    r.part = PART_DELIM;
                    nxt = PH_FRAG;
                end else begin
                    r.part = PART_PATH;
                end
            end
            PH_QUERY: begin
                if (c == CHAR_HASH) begin
                    r.part = PART_DELIM;
                    nxt = PH_FRAG;
                end else begin
                    r.part = PART_QUERY;
                end
            end
            PH_FRAG: begin
                r.part = PART_FRAG;
            end
            default: begin
                nxt = PH_REJECT;
            end
        endcase
        if (nxt == PH_REJECT) begin
            r.verdict = VERDICT_REJECT;
        end else if (lst) begin
            r.verdict = (nxt == PH_PATH || nxt == PH_QUERY || nxt == PH_FRAG) ?
                        VERDICT_ACCEPT : VERDICT_REJECT;
        end
        url_phase = lst ? PH_SCHEME : nxt;
        return r;
    endfunction

    task automatic put(input logic [7:0] c, input logic lst, input logic typed,
                       input part_t p, input verdict_t v);
        stim_t s;
        s.ch = c;
        s.is_last = lst;
        s.typed = typed;
        s.part = p;
        s.verdict = v;
        stim.push_back(s);
    endtask

    function automatic logic [7:0] any_but(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] c;
        c = 8'($urandom);
        while (c == a || c == b) c = 8'($urandom);
        return c;
    endfunction

    // one random url: mostly well formed, some cut short, corrupted or pure noise
    task automatic gen_url();
        logic [7:0] u[$];
        int         kind;
        int         n;
        int         i;
        kind = $urandom_range(0, 9);
        if (kind == 0) begin
            n = $urandom_range(1, 8);
            for (i = 0; i < n; i++) u.push_back(8'($urandom));
        end else begin
            n = $urandom_range(0, 6);
            for (i = 0; i < n; i++) begin
                u.push_back($urandom_range(0, 1) ? 8'(8'h41 + $urandom_range(0, 25)) :
                                                   8'(8'h61 + $urandom_range(0, 25)));
            end
            u.push_back(CHAR_COLON);
            u.push_back(CHAR_SLASH);
            u.push_back(CHAR_SLASH);
            n = $urandom_range(0, 8);
            for (i = 0; i < n; i++) u.push_back(any_but(CHAR_COLON, CHAR_SLASH));
            if ($urandom_range(0, 1)) begin
                u.push_back(CHAR_COLON);
                n = $urandom_range(0, 5);
                for (i = 0; i < n; i++) begin
                    u.push_back($urandom_range(0, 7) == 0 ? CHAR_COLON :
                                any_but(CHAR_SLASH, CHAR_SLASH));
                end
            end
            u.push_back(CHAR_SLASH);
            n = $urandom_range(0, 8);
            for (i = 0; i < n; i++) u.push_back(any_but(CHAR_QMARK, CHAR_HASH));
            if ($urandom_range(0, 1)) begin
                u.push_back(CHAR_QMARK);
                n = $urandom_range(0, 6);
                for (i = 0; i < n; i++) u.push_back(any_but(CHAR_HASH, CHAR_HASH));
            end
            if ($urandom_range(0, 1)) begin
                u.push_back(CHAR_HASH);
                n = $urandom_range(0, 6);
                for (i = 0; i < n; i++) u.push_back(8'($urandom));
            end
            if (kind == 1) begin
                n = $urandom_range(1, u.size());
                while (u.size() > n) void'(u.pop_back());
            end else if (kind == 2) begin
                u[$urandom_range(0, u.size() - 1)] = 8'($urandom);
            end
        end
        for (i = 0; i < u.size(); i++) begin
            put(u[i], i == u.size() - 1, 1'b0, PART_SCHEME, VERDICT_PENDING);
        end
    endtask

    task automatic report(input string field, input logic [7:0] got, input logic [7:0] want);
        $display("mismatch on %s at word %0d: got %0h, want %0h", field, words_out, got, want);
        errors++;
    endtask

    // result check and expectation push, both sampled at the edge
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                got_w = '{m_char_out, part_t'(m_part), verdict_t'(m_verdict), m_end_out};
                if (want_q.size() == 0) begin
                    report("unexpected word", m_char_out, 8'h00);
                end else begin
                    want_w = want_q.pop_front();
                    if (got_w.byte_val != want_w.byte_val)
                        report("char_out", got_w.byte_val, want_w.byte_val);
                    if (got_w.part != want_w.part)
                        report("part", 8'(got_w.part), 8'(want_w.part));
                    if (got_w.verdict != want_w.verdict)
                        report("verdict", 8'(got_w.verdict), 8'(want_w.verdict));
                    if (got_w.is_last != want_w.is_last)
                        report("end_out", 8'(got_w.is_last), 8'(want_w.is_last));
                end
                words_out++;
            end
            if (s_valid && s_ready) begin
                cur_s = stim[words_in];
                pred_w = tag_byte(cur_s.ch, cur_s.is_last);
                if (cur_s.typed) begin
                    pred_w.part = cur_s.part;
                    pred_w.verdict = cur_s.verdict;
                end
                want_q.push_back(pred_w);
                words_in++;
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("tb: errors");
                $finish;
            end
        end
    end

    // receiver
    initial begin
        int hold;
        bit burst;
        m_ready = 1'b0;
        burst = 0;
        do @(posedge aclk); while (!aresetn);
        forever begin
            if ($urandom_range(0, 39) == 0) burst = !burst;
            if (!stall_done && words_in >= STALL_AFTER) begin
                hold = STALL_CYCLES;
                stall_done = 1;
            end else begin
                hold = burst ? 0 : $urandom_range(0, 14);
            end
            if (hold > 0) begin
                m_ready <= 1'b0;
                repeat (hold) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    // stimulus and end of run
    initial begin
        int  k;
        int  gap;
        bit  burst;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_char_in = 8'h00;
        s_end_mark = 1'b0;
        burst = 0;

        // directed table: empty scheme, port with colon, every delimiter
        put(CHAR_COLON, 1'b0, 1'b1, PART_DELIM, VERDICT_PENDING);
        put(CHAR_SLASH, 1'b0, 1'b0, PART_SCHEME, VERDICT_PENDING);
        put(CHAR_SLASH, 1'b0, 1'b0, PART_SCHEME, VERDICT_PENDING);
        put(8'h68,      1'b0, 1'b0, PART_SCHEME, VERDICT_PENDING);
        put(CHAR_COLON, 1'b0, 1'b0, PART_SCHEME, VERDICT_PENDING);
        put(8'h38,      1'b0, 1'b0, PART_SCHEME, VERDICT_PENDING);
        put(CHAR_COLON, 1'b0, 1'b0, PART_SCHEME, VERDICT_PENDING);
        put(CHAR_SLASH, 1'b0, 1'b0, PART_SCHEME, VERDICT_PENDING);
        put(CHAR_SLASH, 1'b0, 1'b0, PART_SCHEME, VERDICT_PENDING);
        put(CHAR_QMARK, 1'b0, 1'b0, PART_SCHEME, VERDICT_PENDING);
        put(CHAR_SLASH, 1'b0, 1'b0, PART_SCHEME, VERDICT_PENDING);
        put(CHAR_HASH,  1'b0, 1'b0, PART_SCHEME, VERDICT_PENDING);
        put(CHAR_QMARK, 1'b0, 1'b0, PART_SCHEME, VERDICT_PENDING);
        put(CHAR_HASH,  1'b1, 1'b1, PART_FRAG,   VERDICT_ACCEPT);
        // zero byte in the scheme
        put(8'h00,      1'b1, 1'b1, PART_IGNORED, VERDICT_REJECT);
        // bad scheme byte, then rejected tail
        put(8'h5A,      1'b0, 1'b0, PART_SCHEME, VERDICT_PENDING);
        put(8'h61,      1'b0, 1'b0, PART_SCHEME, VERDICT_PENDING);
        put(8'hFF,      1'b0, 1'b1, PART_IGNORED, VERDICT_REJECT);
        put(8'h78,      1'b1, 1'b1, PART_IGNORED, VERDICT_REJECT);
        // end in the scheme keeps its tag
        put(8'h7A,      1'b1, 1'b1, PART_SCHEME, VERDICT_REJECT);
        // end right after the path slash
        put(8'h61,      1'b0, 1'b0, PART_SCHEME, VERDICT_PENDING);
        put(CHAR_COLON, 1'b0, 1'b0, PART_SCHEME, VERDICT_PENDING);
        put(CHAR_SLASH, 1'b0, 1'b0, PART_SCHEME, VERDICT_PENDING);
        put(CHAR_SLASH, 1'b0, 1'b0, PART_SCHEME, VERDICT_PENDING);
        put(8'h68,      1'b0, 1'b0, PART_SCHEME, VERDICT_PENDING);
        put(CHAR_SLASH, 1'b1, 1'b1, PART_DELIM,  VERDICT_ACCEPT);

        k = stim.size();
        while (stim.size() < k + RANDOM_WORDS) gen_url();

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        for (k = 0; k < stim.size(); k++) begin
            if ($urandom_range(0, 31) == 0) burst = !burst;
            gap = burst ? 0 : $urandom_range(0, 14);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            s_valid <= 1'b1;
            s_char_in <= stim[k].ch;
            s_end_mark <= stim[k].is_last;
            do @(posedge aclk); while (!s_ready);
        end
        s_valid <= 1'b0;

        while (words_out < stim.size()) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (errors == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

endmodule
